[design/prdp_pkg.sv]
// Package for the printer row dither and pack block.
// Holds shared constants, register indexes and the controller/datapath command types.
// No dependencies.
package prdp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_DENSITY     = 3'd1;
  localparam logic [2:0] CFG_PASS_STRIDE = 3'd2;
  localparam logic [2:0] CFG_DROW0       = 3'd3;
  localparam logic [2:0] CFG_DROW1       = 3'd4;
  localparam logic [2:0] CFG_DROW2       = 3'd5;
  localparam logic [2:0] CFG_DROW3       = 3'd6;

  // Vertical density codes.
  localparam logic [1:0] DENS_SINGLE = 2'd0;
  localparam logic [1:0] DENS_144    = 2'd1;
  localparam logic [1:0] DENS_216    = 2'd2;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REP_W      = 7;
  localparam logic [REP_W-1:0] MAX_REPEAT = 7'd64;

  // Division by three of a 16-bit row: (row * 43691) >> 17 is exact.
  localparam logic [15:0] DIV3_MUL   = 16'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  localparam logic [3:0] THR_FLIP  = 4'd15;
  localparam logic [7:0] MASK_TOP  = 8'h80;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input item
    logic div;      // compute the dither row number
    logic row;      // latch the row start, mask and dither select
    logic emit;     // load one result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // output register is empty or being taken
    logic last_beat;  // the next result is the last of the item
  } status_t;

endpackage

[design/prdp_if.sv]
// Channel interfaces for the printer row dither and pack block.
// Input pixel channel and result channel; no dependencies.
interface prdp_in_if;
  logic        valid;
  logic        ready;
  logic        start_row;
  logic [15:0] row;
  logic [11:0] x_start;
  logic [7:0]  black;
  logic [6:0]  repeat_req;

  modport source (output valid, start_row, row, x_start, black, repeat_req, input ready);
  modport sink   (input valid, start_row, row, x_start, black, repeat_req, output ready);
endinterface

interface prdp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] byte_index;
  logic [7:0]  bit_mask;
  logic        mark;
  logic        last;

  modport source (output valid, byte_index, bit_mask, mark, last, input ready);
  modport sink   (input valid, byte_index, bit_mask, mark, last, output ready);
endinterface

[design/prdp_ctrl.sv]
// Controller state machine of the printer row dither and pack block.
// Depends on prdp_pkg for the command and status types.
module prdp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_start_row,
  output logic              in_ready,
  input  prdp_pkg::status_t sts,
  output prdp_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Commands follow the current state.
  always_comb begin
    cmd.capture = accept;
    cmd.div     = (state_r == ST_DIV);
    cmd.row     = (state_r == ST_ROW);
    cmd.emit    = (state_r == ST_EMIT) && sts.slot_free;
  end

  // Next state: a row start goes through the two row latch steps first.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_start_row ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV:  state_nxt = ST_ROW;
      ST_ROW:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.slot_free && sts.last_beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/prdp_dp.sv]
// Datapath of the printer row dither and pack block: configuration registers,
// row state, repeat counter and output register. Depends on prdp_pkg.
module prdp_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [prdp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]                     in_row,
  input  logic [11:0]                     in_x_start,
  input  logic [7:0]                      in_black,
  input  logic [6:0]                      in_repeat_req,
  input  prdp_pkg::cmd_t                  cmd,
  output prdp_pkg::status_t               sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [15:0]                     out_byte_index,
  output logic [7:0]                      out_bit_mask,
  output logic                            out_mark,
  output logic                            out_last
);

  // Configuration registers.
  logic [3:0]  thr_r;
  logic [1:0]  dens_r;
  logic [15:0] stride_r;
  logic [31:0] drow_r [4];

  // Captured item and row state.
  logic [15:0] row_q_r;
  logic [11:0] xs_q_r;
  logic [7:0]  black_r;
  logic [prdp_pkg::REP_W-1:0] cnt_r;
  logic [15:0] y_r;
  logic [15:0] dest_r;
  logic [1:0]  col_r;
  logic [7:0]  mask_r;
  logic [1:0]  sel_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_idx_r;
  logic [7:0]  out_mask_r;
  logic        out_mark_r;
  logic        out_last_r;

  logic [prdp_pkg::REP_W-1:0] rep_clamped;
  logic [31:0] div3_prod;
  logic [15:0] y_nxt;
  logic [15:0] three_q;
  logic [15:0] rem3;
  logic [1:0]  pass_sel;
  logic [15:0] offset;
  logic [31:0] drow_sel;
  logic [7:0]  dvalue;
  logic        mark_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      dens_r    <= prdp_pkg::DENS_SINGLE;
      stride_r  <= '0;
      drow_r[0] <= '0;
      drow_r[1] <= '0;
      drow_r[2] <= '0;
      drow_r[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prdp_pkg::CFG_THRESHOLD:   thr_r     <= cfg_wdata[3:0];
        prdp_pkg::CFG_DENSITY:     dens_r    <= cfg_wdata[1:0];
        prdp_pkg::CFG_PASS_STRIDE: stride_r  <= cfg_wdata[15:0];
        prdp_pkg::CFG_DROW0:       drow_r[0] <= cfg_wdata;
        prdp_pkg::CFG_DROW1:       drow_r[1] <= cfg_wdata;
        prdp_pkg::CFG_DROW2:       drow_r[2] <= cfg_wdata;
        prdp_pkg::CFG_DROW3:       drow_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Repeat count: zero counts as one, large values saturate.
  always_comb begin
    if (in_repeat_req == '0) begin
      rep_clamped = prdp_pkg::REP_W'(1);
    end else if (in_repeat_req > prdp_pkg::MAX_REPEAT) begin
      rep_clamped = prdp_pkg::MAX_REPEAT;
    end else begin
      rep_clamped = in_repeat_req;
    end
  end

  // Step one of the row latch: the dither row number y.
  assign div3_prod = row_q_r * prdp_pkg::DIV3_MUL;
  always_comb begin
    case (dens_r)
      prdp_pkg::DENS_216: y_nxt = 16'(div3_prod >> prdp_pkg::DIV3_SHIFT);
      prdp_pkg::DENS_144: y_nxt = {1'b0, row_q_r[15:1]};
      default:            y_nxt = row_q_r;
    endcase
  end

  // Step two: the pass number and its byte offset.
  assign three_q = 16'(y_r * 16'd3);
  assign rem3    = row_q_r - three_q;
  always_comb begin
    case (dens_r)
      prdp_pkg::DENS_216: pass_sel = rem3[1:0];
      prdp_pkg::DENS_144: pass_sel = {1'b0, row_q_r[0]};
      default:            pass_sel = 2'd0;
    endcase
    case (pass_sel)
      2'd1:    offset = stride_r;
      2'd2:    offset = {stride_r[14:0], 1'b0};
      default: offset = '0;
    endcase
  end

  // Comparison value: fixed threshold or the ordered dither entry.
  assign drow_sel = drow_r[sel_r];
  always_comb begin
    if (thr_r != '0) begin
      dvalue = {4'd0, thr_r ^ prdp_pkg::THR_FLIP};
    end else begin
      dvalue = drow_sel[{col_r, 3'b000} +: 8];
    end
    mark_nxt = (black_r > dvalue);
  end

  // Captured item, row state and repeat counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= '0;
      col_r  <= '0;
      mask_r <= prdp_pkg::MASK_TOP;
      sel_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.capture) begin
        cnt_r <= rep_clamped;
      end else if (cmd.emit) begin
        cnt_r <= cnt_r - prdp_pkg::REP_W'(1);
      end
      if (cmd.row) begin
        dest_r <= {4'd0, xs_q_r} + offset;
        col_r  <= xs_q_r[1:0];
        mask_r <= prdp_pkg::MASK_TOP >> y_r[2:0];
        sel_r  <= y_r[1:0];
      end else if (cmd.emit) begin
        dest_r <= dest_r + 16'd1;
        col_r  <= col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_q_r <= in_row;
      xs_q_r  <= in_x_start;
      black_r <= in_black;
    end
    if (cmd.div) begin
      y_r <= y_nxt;
    end
  end

  // Output register: loaded on emit, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= dest_r;
      out_mask_r <= mask_r;
      out_mark_r <= mark_nxt;
      out_last_r <= sts.last_beat;
    end
  end

  always_comb begin
    sts.slot_free = !out_valid_r || out_ready;
    sts.last_beat = (cnt_r == prdp_pkg::REP_W'(1));
  end

  assign out_valid      = out_valid_r;
  assign out_byte_index = out_idx_r;
  assign out_bit_mask   = out_mask_r;
  assign out_mark       = out_mark_r;
  assign out_last       = out_last_r;

endmodule

[design/printer_row_dither_pack.sv]
// Top level of the printer row dither and pack block.
// Depends on prdp_pkg, prdp_if, prdp_ctrl and prdp_dp.
//
//  Channel  | Direction | Carries
//  in_bus   | sink      | start_row, row, x_start, black, repeat_req
//  out_bus  | source    | byte_index, bit_mask, mark, last
//  cfg_*    | write     | cfg_we, cfg_index, cfg_wdata (32 bits)
//
// An item without a row start is captured first, then its results go into the
// output register one per cycle while the output is not stalled. A row start
// adds the two row latch steps (divide by three, then offset and mask).
// rst_n is synchronous, active low; resets config, row state, counter, out_valid.
// A stalled output holds the result and pauses the counter; the next item is
// taken while the last result still waits.
module printer_row_dither_pack (
  input  logic                            clk,
  input  logic                            rst_n,
  prdp_in_if.sink                         in_bus,
  prdp_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [prdp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  prdp_pkg::cmd_t    cmd;
  prdp_pkg::status_t sts;

  prdp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_start_row (in_bus.start_row),
    .in_ready     (in_bus.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  prdp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_row         (in_bus.row),
    .in_x_start     (in_bus.x_start),
    .in_black       (in_bus.black),
    .in_repeat_req  (in_bus.repeat_req),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_bus.ready),
    .out_valid      (out_bus.valid),
    .out_byte_index (out_bus.byte_index),
    .out_bit_mask   (out_bus.bit_mask),
    .out_mark       (out_bus.mark),
    .out_last       (out_bus.last)
  );

endmodule
